FILE: hw/rtl/best_threshold_run_finder_macros.svh
// Assertion macros shared by the run finder's checker files.
// Standalone header; expects a clock and an active-low reset name as arguments.
`ifndef BEST_THRESHOLD_RUN_FINDER_MACROS_SVH
`define BEST_THRESHOLD_RUN_FINDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/btrf_pkg.sv
// Shared types and constants for the best threshold run finder.
// No dependencies; used by btrf_arith, the top level and the checker.
package btrf_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int SCORE_W   = 18;
  localparam int SUM_W     = 26;
  localparam int LEN_W     = 9;
  localparam int IDX_W     = 8;
  localparam int PROD_W    = SUM_W + LEN_W;
  localparam int CNT_W     = $clog2(SUM_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [IDX_W-1:0]     IDX_MAX   = IDX_W'(MAX_ITEMS - 1);
  localparam logic [SUM_W-1:0]     SUM_MAX   = '1;
  localparam logic [LEN_W-1:0]     LEN_MAX   = '1;
  localparam logic [CNT_W-1:0]     MUL_STEPS = CNT_W'(LEN_W);
  localparam logic [CNT_W-1:0]     DIV_STEPS = CNT_W'(SUM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN   = CFG_IDX_W'(1);

  localparam logic [LEN_W-1:0]     MIN_RUN_RESET = LEN_W'(4);

  typedef enum logic {
    ARITH_MUL = 1'b0,
    ARITH_DIV = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] result;
  } arith_rsp_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   run_begin;
    logic [IDX_W-1:0]   run_finish;
    logic [SCORE_W-1:0] mean_score;
  } out_item_t;

endpackage

FILE: hw/rtl/best_threshold_run_finder.sv
// Best threshold run finder. A beat that neither closes a run nor is last leaves it idle.
// Closing a run goes through S_CLOSE, then through S_MUL1 and S_MUL2 when two 9-step
// multiplies compare it with the best. A last beat adds a 26-step divide when a run was
// found. Input is taken again once S_EMIT has loaded the result; S_EMIT waits out a stall.
// Synchronous active-low reset clears the control registers, threshold to 0, min run to 4.
// Depends on btrf_pkg and btrf_arith.
module best_threshold_run_finder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  btrf_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output btrf_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [btrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btrf_pkg::SCORE_W-1:0]     cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLOSE = 7'b0000010,
    S_MUL1  = 7'b0000100,
    S_MUL2  = 7'b0001000,
    S_FINAL = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [btrf_pkg::SCORE_W-1:0]   thr_r;
  logic [btrf_pkg::LEN_W-1:0]     min_len_r;
  logic [btrf_pkg::IDX_W-1:0]     item_idx_r, item_idx_nxt;
  logic                           in_run_r, in_run_nxt;
  logic [btrf_pkg::IDX_W-1:0]     run_start_r, run_start_nxt;
  logic [btrf_pkg::SUM_W-1:0]     run_sum_r, run_sum_nxt;
  logic [btrf_pkg::LEN_W-1:0]     run_len_r, run_len_nxt;
  logic                           best_valid_r, best_valid_nxt;
  logic [btrf_pkg::IDX_W-1:0]     best_start_r, best_start_nxt;
  logic [btrf_pkg::IDX_W-1:0]     best_end_r, best_end_nxt;
  logic [btrf_pkg::SUM_W-1:0]     best_sum_r, best_sum_nxt;
  logic [btrf_pkg::LEN_W-1:0]     best_len_r, best_len_nxt;
  logic                           last_r, last_nxt;
  logic [btrf_pkg::PROD_W-1:0]    p1_r, p1_nxt;
  btrf_pkg::out_item_t            res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  btrf_pkg::out_item_t            out_data_r, out_data_nxt;

  btrf_pkg::arith_req_t           req;
  btrf_pkg::arith_rsp_t           rsp;
  logic [btrf_pkg::SUM_W-1:0]     opa;
  logic [btrf_pkg::LEN_W-1:0]     opb;

  logic                           accept;
  logic                           score_ge;
  logic [btrf_pkg::SUM_W:0]       sum_ext;
  logic                           qualify;
  logic [btrf_pkg::IDX_W+1:0]     end_ext;
  logic [btrf_pkg::IDX_W-1:0]     run_end;
  logic                           take;
  logic                           close_done;

  btrf_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .opa   (opa),
    .opb   (opb),
    .rsp   (rsp)
  );

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept   = in_valid && !in_stall;
  assign score_ge = in_data.score >= thr_r;
  assign sum_ext  = {1'b0, run_sum_r} + (btrf_pkg::SUM_W + 1)'(in_data.score);
  assign qualify  = in_run_r && (run_len_r >= min_len_r) && (run_len_r != '0);
  assign end_ext  = (btrf_pkg::IDX_W + 2)'(run_start_r) + (btrf_pkg::IDX_W + 2)'(run_len_r)
                    - (btrf_pkg::IDX_W + 2)'(1);
  assign run_end  = (end_ext > (btrf_pkg::IDX_W + 2)'(btrf_pkg::IDX_MAX))
                    ? btrf_pkg::IDX_MAX : end_ext[btrf_pkg::IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    item_idx_nxt   = item_idx_r;
    in_run_nxt     = in_run_r;
    run_start_nxt  = run_start_r;
    run_sum_nxt    = run_sum_r;
    run_len_nxt    = run_len_r;
    best_valid_nxt = best_valid_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    best_sum_nxt   = best_sum_r;
    best_len_nxt   = best_len_r;
    last_nxt       = last_r;
    p1_nxt         = p1_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    req.start      = 1'b0;
    req.op         = btrf_pkg::ARITH_MUL;
    opa            = run_sum_r;
    opb            = best_len_r;
    take           = 1'b0;
    close_done     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (score_ge) begin
            in_run_nxt = 1'b1;
            if (!in_run_r) begin
              run_start_nxt = item_idx_r;
              run_sum_nxt   = btrf_pkg::SUM_W'(in_data.score);
              run_len_nxt   = btrf_pkg::LEN_W'(1);
            end else begin
              run_sum_nxt = sum_ext[btrf_pkg::SUM_W] ? btrf_pkg::SUM_MAX
                                                     : sum_ext[btrf_pkg::SUM_W-1:0];
              if (run_len_r != btrf_pkg::LEN_MAX) begin
                run_len_nxt = run_len_r + 1'b1;
              end
            end
          end
          if (!in_data.last && (item_idx_r != btrf_pkg::IDX_MAX)) begin
            item_idx_nxt = item_idx_r + 1'b1;
          end
          last_nxt = in_data.last;
          if (!score_ge || in_data.last) begin
            state_nxt = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (!qualify) begin
          close_done = 1'b1;
        end else if (!best_valid_r) begin
          take       = (run_sum_r != '0);
          close_done = 1'b1;
        end else begin
          req.start = 1'b1;
          req.op    = btrf_pkg::ARITH_MUL;
          opa       = run_sum_r;
          opb       = best_len_r;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        if (rsp.done) begin
          p1_nxt    = rsp.result;
          req.start = 1'b1;
          req.op    = btrf_pkg::ARITH_MUL;
          opa       = best_sum_r;
          opb       = run_len_r;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (rsp.done) begin
          take       = (p1_r > rsp.result);
          close_done = 1'b1;
        end
      end
      S_FINAL: begin
        if (best_valid_r && (best_len_r != '0)) begin
          req.start = 1'b1;
          req.op    = btrf_pkg::ARITH_DIV;
          opa       = best_sum_r;
          opb       = best_len_r;
          state_nxt = S_DIV;
        end else begin
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        if (rsp.done) begin
          res_nxt.found      = 1'b1;
          res_nxt.run_begin  = best_start_r;
          res_nxt.run_finish = best_end_r;
          res_nxt.mean_score = rsp.result[btrf_pkg::SCORE_W-1:0];
          state_nxt          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt   = res_r;
          out_valid_nxt  = 1'b1;
          item_idx_nxt   = '0;
          in_run_nxt     = 1'b0;
          run_start_nxt  = '0;
          run_sum_nxt    = '0;
          run_len_nxt    = '0;
          best_valid_nxt = 1'b0;
          best_start_nxt = '0;
          best_end_nxt   = '0;
          best_sum_nxt   = '0;
          best_len_nxt   = '0;
          last_nxt       = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (take) begin
      best_valid_nxt = 1'b1;
      best_start_nxt = run_start_r;
      best_end_nxt   = run_end;
      best_sum_nxt   = run_sum_r;
      best_len_nxt   = run_len_r;
    end

    if (close_done) begin
      in_run_nxt  = 1'b0;
      run_sum_nxt = '0;
      run_len_nxt = '0;
      state_nxt   = last_r ? S_FINAL : S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      thr_r        <= '0;
      min_len_r    <= btrf_pkg::MIN_RUN_RESET;
      item_idx_r   <= '0;
      in_run_r     <= 1'b0;
      run_start_r  <= '0;
      run_sum_r    <= '0;
      run_len_r    <= '0;
      best_valid_r <= 1'b0;
      best_start_r <= '0;
      best_end_r   <= '0;
      best_sum_r   <= '0;
      best_len_r   <= '0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      item_idx_r   <= item_idx_nxt;
      in_run_r     <= in_run_nxt;
      run_start_r  <= run_start_nxt;
      run_sum_r    <= run_sum_nxt;
      run_len_r    <= run_len_nxt;
      best_valid_r <= best_valid_nxt;
      best_start_r <= best_start_nxt;
      best_end_r   <= best_end_nxt;
      best_sum_r   <= best_sum_nxt;
      best_len_r   <= best_len_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == btrf_pkg::CFG_THRESHOLD) begin
          thr_r <= cfg_data;
        end else if (cfg_index == btrf_pkg::CFG_MIN_RUN) begin
          min_len_r <= cfg_data[btrf_pkg::LEN_W-1:0];
        end
      end
    end
    p1_r       <= p1_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: hw/rtl/btrf_arith.sv
// Shared iterative arithmetic unit: shift-add multiply and restoring divide.
// Depends on btrf_pkg; one adder serves both operations, one bit per cycle.
module btrf_arith (
  input  logic                         clk,
  input  logic                         rst_n,
  input  btrf_pkg::arith_req_t         req,
  input  logic [btrf_pkg::SUM_W-1:0]   opa,
  input  logic [btrf_pkg::LEN_W-1:0]   opb,
  output btrf_pkg::arith_rsp_t         rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  btrf_pkg::arith_op_t           op_r, op_nxt;
  logic [btrf_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [btrf_pkg::PROD_W-1:0]   acc_r, acc_nxt;
  logic [btrf_pkg::SUM_W-1:0]    a_r, a_nxt;
  logic [btrf_pkg::LEN_W-1:0]    b_r, b_nxt;
  logic [btrf_pkg::LEN_W-1:0]    rem_r, rem_nxt;

  logic [btrf_pkg::LEN_W:0]      rem_t;
  logic [btrf_pkg::PROD_W-1:0]   add_x, add_y, add_sum;
  logic                          add_cin;
  logic                          neg;

  always_comb begin
    rem_t = {rem_r, a_r[btrf_pkg::SUM_W-1]};
    unique case (op_r)
      btrf_pkg::ARITH_MUL: begin
        add_x   = {acc_r[btrf_pkg::PROD_W-2:0], 1'b0};
        add_y   = b_r[btrf_pkg::LEN_W-1] ? btrf_pkg::PROD_W'(a_r) : '0;
        add_cin = 1'b0;
      end
      btrf_pkg::ARITH_DIV: begin
        add_x   = btrf_pkg::PROD_W'(rem_t);
        add_y   = ~btrf_pkg::PROD_W'(b_r);
        add_cin = 1'b1;
      end
      default: begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
      end
    endcase
    add_sum = add_x + add_y + btrf_pkg::PROD_W'(add_cin);
    neg     = add_sum[btrf_pkg::PROD_W-1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      unique case (op_r)
        btrf_pkg::ARITH_MUL: begin
          acc_nxt = add_sum;
          b_nxt   = {b_r[btrf_pkg::LEN_W-2:0], 1'b0};
        end
        btrf_pkg::ARITH_DIV: begin
          rem_nxt = neg ? rem_t[btrf_pkg::LEN_W-1:0] : add_sum[btrf_pkg::LEN_W-1:0];
          a_nxt   = {a_r[btrf_pkg::SUM_W-2:0], 1'b0};
          acc_nxt = {acc_r[btrf_pkg::PROD_W-2:0], ~neg};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      acc_nxt  = '0;
      rem_nxt  = '0;
      a_nxt    = opa;
      b_nxt    = opb;
      cnt_nxt  = (req.op == btrf_pkg::ARITH_MUL) ? btrf_pkg::MUL_STEPS - 1'b1
                                                 : btrf_pkg::DIV_STEPS - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= btrf_pkg::ARITH_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

FILE: hw/rtl/btrf_checker.sv
// Port-level checker for the best threshold run finder, bound to the top level.
// Depends on btrf_pkg and best_threshold_run_finder_macros.svh.
`include "best_threshold_run_finder_macros.svh"

module btrf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input btrf_pkg::in_item_t               in_data,
  input logic                             out_valid,
  input logic                             out_stall,
  input btrf_pkg::out_item_t              out_data,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [btrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [btrf_pkg::SCORE_W-1:0]     cfg_data
);

  logic in_beat;
  logic cfg_beat;

  assign in_beat  = in_valid && !in_stall;
  assign cfg_beat = cfg_valid && cfg_ready && (cfg_index != '0 || cfg_data != '0);

  // A result that is held back keeps its valid and its value.
  `BTRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // A sequence with no qualifying run reports all fields as zero.
  `BTRF_ASSERT_IMPLY(a_none_zero, clk, rst_n, out_valid && !out_data.found, (out_data.run_begin == '0) && (out_data.run_finish == '0) && (out_data.mean_score == '0))

  // A reported run never ends before it begins.
  `BTRF_ASSERT_IMPLY(a_run_order, clk, rst_n, out_valid && out_data.found, out_data.run_begin <= out_data.run_finish)

  // A beat that is not the last one never brings out a new result.
  `BTRF_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_beat && !in_data.last && !out_valid && !cfg_beat, !out_valid)

endmodule

bind best_threshold_run_finder btrf_checker u_btrf_checker (.*);
